@@ hw/rtl/upd_pkg.sv @@
// Shared constants, register indexes and transaction types of the presence detector.
package upd_pkg;

    localparam int TIME_BITS = 20;
    localparam int DIST_BITS = TIME_BITS + 1;
    localparam int TRIG_BITS = 8;
    localparam int DEB_BITS  = 4;
    localparam int CFG_BITS  = (TIME_BITS > TRIG_BITS) ? TIME_BITS : TRIG_BITS;
    localparam int IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_TRIGGER  = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_MAX_ECHO = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_DEBOUNCE = 2'd3;

    localparam logic [TIME_BITS-1:0] TIMEOUT_RST  = TIME_BITS'(100000);
    localparam logic [TRIG_BITS-1:0] TRIGGER_RST  = TRIG_BITS'(10);
    localparam logic [TIME_BITS-1:0] MAX_ECHO_RST = TIME_BITS'(9411);
    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RST = DEB_BITS'(6);

    typedef struct packed {
        logic start_req;
        logic echo;
    } t_in_item;

    typedef struct packed {
        logic                 trigger;
        logic                 busy_res;
        logic                 done_res;
        logic                 timed_out;
        logic [TIME_BITS-1:0] echo_time_us;
        logic [DIST_BITS-1:0] distance_centi_cm;
        logic                 present;
        logic                 present_changed;
    } t_out_item;

    typedef struct packed {
        logic [TIME_BITS-1:0] timeout_us;
        logic [TRIG_BITS-1:0] trigger_ticks;
        logic [TIME_BITS-1:0] max_echo_us;
        logic [DEB_BITS-1:0]  debounce_scans;
    } t_cfg;

endpackage

@@ hw/rtl/upd_in_if.sv @@
// Valid/ready channel that carries one input sample tick.
interface upd_in_if;
    logic              valid;
    logic              ready;
    upd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/upd_out_if.sv @@
// Valid/ready channel that carries one result per sample tick.
interface upd_out_if;
    logic               valid;
    logic               ready;
    upd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/upd_cfg_regs.sv @@
// Configuration register file written through the plain write port.
module upd_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [upd_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [upd_pkg::CFG_BITS-1:0] i_cfg_data,
    output upd_pkg::t_cfg                o_cfg
);

    upd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_us     <= upd_pkg::TIMEOUT_RST;
            r_cfg.trigger_ticks  <= upd_pkg::TRIGGER_RST;
            r_cfg.max_echo_us    <= upd_pkg::MAX_ECHO_RST;
            r_cfg.debounce_scans <= upd_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                upd_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout_us <= i_cfg_data[upd_pkg::TIME_BITS-1:0];
                end
                upd_pkg::CFG_TRIGGER: begin
                    r_cfg.trigger_ticks <= i_cfg_data[upd_pkg::TRIG_BITS-1:0];
                end
                upd_pkg::CFG_MAX_ECHO: begin
                    r_cfg.max_echo_us <= i_cfg_data[upd_pkg::TIME_BITS-1:0];
                end
                upd_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_scans <= i_cfg_data[upd_pkg::DEB_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/upd_range.sv @@
// Echo time to distance conversion, times 17 and divided by 10 through a reciprocal.
module upd_range (
    input  logic [upd_pkg::TIME_BITS-1:0] i_echo_time,
    output logic [upd_pkg::DIST_BITS-1:0] o_distance
);

    localparam int X_BITS      = upd_pkg::TIME_BITS + 5;
    localparam int SHIFT       = upd_pkg::TIME_BITS + 9;
    localparam int RECIP_BITS  = upd_pkg::TIME_BITS + 6;
    localparam int PROD_BITS   = X_BITS + RECIP_BITS;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd9) / 64'd10;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

    logic [X_BITS-1:0]    x;
    logic [PROD_BITS-1:0] prod;

    assign x    = {1'b0, i_echo_time, 4'b0000} + {5'b00000, i_echo_time};
    assign prod = {{RECIP_BITS{1'b0}}, x} * {{X_BITS{1'b0}}, RECIP};
    assign o_distance = prod[SHIFT+upd_pkg::DIST_BITS-1:SHIFT];

endmodule

@@ hw/rtl/upd_scan_fsm.sv @@
// Scan sequencer with echo timing, timeout check and presence debounce.
module upd_scan_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  upd_pkg::t_in_item  i_item,
    input  upd_pkg::t_cfg      i_cfg,
    output upd_pkg::t_out_item o_res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    logic [1:0]                    r_phase, n_phase;
    logic [upd_pkg::TRIG_BITS-1:0] r_trig_cnt, n_trig_cnt;
    logic [upd_pkg::DIST_BITS-1:0] r_elapsed, n_elapsed;
    logic [upd_pkg::TIME_BITS-1:0] r_high, n_high;
    logic                          r_level, n_level;
    logic [upd_pkg::DEB_BITS-1:0]  r_disagree, n_disagree;

    logic [upd_pkg::TRIG_BITS-1:0] need_trig;
    logic [upd_pkg::DEB_BITS-1:0]  need_deb;
    logic [upd_pkg::DEB_BITS-1:0]  dis_inc;
    logic [upd_pkg::DIST_BITS-1:0] elapsed_inc;
    logic [upd_pkg::DIST_BITS-1:0] timeout_ext;
    logic [upd_pkg::TIME_BITS-1:0] etime;
    logic [upd_pkg::DIST_BITS-1:0] distance;
    logic trig, busy, done, tout, changed, sample;

    assign need_trig   = (i_cfg.trigger_ticks == '0) ? upd_pkg::TRIG_BITS'(1)
                                                     : i_cfg.trigger_ticks;
    assign need_deb    = (i_cfg.debounce_scans == '0) ? upd_pkg::DEB_BITS'(1)
                                                      : i_cfg.debounce_scans;
    assign elapsed_inc = r_elapsed + upd_pkg::DIST_BITS'(1);
    assign timeout_ext = {1'b0, i_cfg.timeout_us};

    always_comb begin
        n_phase    = r_phase;
        n_trig_cnt = r_trig_cnt;
        n_elapsed  = r_elapsed;
        n_high     = r_high;
        n_level    = r_level;
        n_disagree = r_disagree;
        trig       = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        tout       = 1'b0;
        changed    = 1'b0;
        etime      = '0;
        sample     = 1'b0;
        dis_inc    = r_disagree + upd_pkg::DEB_BITS'(1);

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    busy       = 1'b1;
                    trig       = 1'b1;
                    n_trig_cnt = upd_pkg::TRIG_BITS'(1);
                    n_elapsed  = '0;
                    n_high     = '0;
                    n_phase    = (need_trig == upd_pkg::TRIG_BITS'(1)) ? PH_WAIT : PH_TRIG;
                end
            end
            PH_TRIG: begin
                busy       = 1'b1;
                trig       = 1'b1;
                n_trig_cnt = r_trig_cnt + upd_pkg::TRIG_BITS'(1);
                if (n_trig_cnt >= need_trig) begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                busy      = 1'b1;
                n_elapsed = elapsed_inc;
                if (i_item.echo) begin
                    n_high  = upd_pkg::TIME_BITS'(1);
                    n_phase = PH_MEAS;
                end else if (elapsed_inc > timeout_ext) begin
                    done = 1'b1;
                    tout = 1'b1;
                end
            end
            PH_MEAS: begin
                busy = 1'b1;
                if (!i_item.echo) begin
                    done  = 1'b1;
                    etime = r_high;
                end else begin
                    n_elapsed = elapsed_inc;
                    n_high    = r_high + upd_pkg::TIME_BITS'(1);
                    if (elapsed_inc > timeout_ext) begin
                        done = 1'b1;
                        tout = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            sample     = (etime != '0) && (etime <= i_cfg.max_echo_us);
            n_disagree = (sample != r_level) ? dis_inc : '0;
            if (n_disagree >= need_deb) begin
                n_level    = sample;
                n_disagree = '0;
                changed    = 1'b1;
            end
            n_phase    = PH_IDLE;
            n_trig_cnt = '0;
            n_elapsed  = '0;
            n_high     = '0;
        end
    end

    upd_range u_range (
        .i_echo_time (etime),
        .o_distance  (distance)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_trig_cnt <= '0;
            r_elapsed  <= '0;
            r_high     <= '0;
            r_level    <= 1'b0;
            r_disagree <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_trig_cnt <= n_trig_cnt;
            r_elapsed  <= n_elapsed;
            r_high     <= n_high;
            r_level    <= n_level;
            r_disagree <= n_disagree;
        end
    end

    always_comb begin
        o_res.trigger           = trig;
        o_res.busy_res          = busy;
        o_res.done_res          = done;
        o_res.timed_out         = tout;
        o_res.echo_time_us      = etime;
        o_res.distance_centi_cm = distance;
        o_res.present           = n_level;
        o_res.present_changed   = changed;
    end

endmodule

@@ hw/rtl/ultrasonic_presence_detector.sv @@
// Top level of the ultrasonic presence detector with input and result registers.
//
// Each transaction on i_in is one microsecond sample tick carrying a scan
// request and the sampled echo level. Each tick produces exactly one result
// transaction on o_out with the trigger drive, busy and done flags, the echo
// time, the distance in hundredths of a centimetre and the debounced presence.
// A tick is captured in an input register, processed by the scan sequencer once
// the result register is free or being read, and written to the result register,
// from which it is offered on o_out. One tick is taken in every cycle while the
// receiver does not stall o_out; the rate is set by the single pass through the
// sequencer and the reciprocal multiplier that converts echo time to distance.
// When the receiver stalls, the result register holds its transaction and the
// input register absorbs one more tick before i_in.ready drops.
// Reset clears the sequencer to idle with presence off and loads the default
// timeout, trigger length, presence limit and debounce count. Configuration
// registers are written through i_cfg_we, i_cfg_idx and i_cfg_data, and the
// user must do so only while no transaction is in flight, which is not enforced.
module ultrasonic_presence_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [upd_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [upd_pkg::CFG_BITS-1:0] i_cfg_data,
    upd_in_if.sink                       i_in,
    upd_out_if.source                    o_out
);

    upd_pkg::t_cfg      cfg;
    upd_pkg::t_out_item res;
    upd_pkg::t_in_item  r_in_data;
    upd_pkg::t_out_item r_out_data;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               advance;
    logic               fire;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    upd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    upd_scan_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_data <= i_in.data;
        end
        if (fire) begin
            r_out_data <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
